[rtl/stwp_pkg.sv]
package stwp_pkg;

	// Field widths of one transaction.
	localparam int IDX_W  = 10;
	localparam int KEY_W  = 64;
	localparam int MOVE_W = 16;
	localparam int WT_W   = 16;
	localparam int CNT_W  = 11;
	localparam int RND_W  = 32;

	// Feedback taps of the Galois generator.
	localparam logic [RND_W-1:0] LFSR_TAPS = 32'h8020_0003;

	// Register indexes on the configuration port.
	localparam logic REG_COUNT = 1'b0;
	localparam logic REG_SEED  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic red_step;
		logic mem_wr;
		logic srch_rd;
		logic srch_upd;
		logic scan_rd;
		logic scan_upd;
		logic rem_start;
		logic pick_upd;
		logic pos_inc;
	} stwp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic red_last;
		logic cnt_zero;
		logic lo_lt_hi;
		logic pos_lt_cnt;
		logic key_eq;
		logic need_rem;
		logic rem_done;
	} stwp_stat_t;

endpackage

[rtl/stwp_ram.sv]
module stwp_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single port with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

[rtl/stwp_rem.sv]
module stwp_rem #(
	parameter int SW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [SW-1:0] divisor,
	output logic [SW-1:0] rem,
	output logic          done
);

	logic          busy_q;
	logic          done_q;
	logic [4:0]    bit_q;
	logic [31:0]   dvd_q;
	logic [SW-1:0] rem_q;
	logic [SW-1:0] div_q;
	logic [SW:0]   trial;
	logic [SW:0]   next_rem;

	// One restoring step: shift in a dividend bit, subtract if it fits.
	always_comb begin
		trial = {rem_q, dvd_q[31]};
		if (trial >= {1'b0, div_q}) begin
			next_rem = trial - {1'b0, div_q};
		end else begin
			next_rem = trial;
		end
	end

	// Control of the bit sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (busy_q) begin
			bit_q <= bit_q + 5'd1;
			if (bit_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and shifting dividend.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= next_rem[SW-1:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

endmodule

[rtl/stwp_dp.sv]
module stwp_dp #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stwp_pkg::stwp_cmd_t           cmd,
	output stwp_pkg::stwp_stat_t          stat,
	input  logic [stwp_pkg::CNT_W-1:0]    entry_count,
	input  logic                          seed_wr,
	input  logic [stwp_pkg::RND_W-1:0]    seed,
	input  logic [stwp_pkg::IDX_W-1:0]    entry_index,
	input  logic [stwp_pkg::KEY_W-1:0]    entry_key,
	input  logic [stwp_pkg::MOVE_W-1:0]   entry_move,
	input  logic [stwp_pkg::WT_W-1:0]     entry_weight,
	input  logic [stwp_pkg::KEY_W-1:0]    probe_key,
	input  logic                          pick_max,
	output logic [stwp_pkg::MOVE_W-1:0]   chosen_move
);

	import stwp_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = ($clog2(TABLE_DEPTH + 1) > CNT_W) ? $clog2(TABLE_DEPTH + 1) : CNT_W;
	localparam int SW = WT_W + $clog2(TABLE_DEPTH + 1);
	localparam int EW = KEY_W + MOVE_W + WT_W;
	localparam logic [30:0] DEPTH_W = 31'(TABLE_DEPTH);
	localparam logic [19:0] RECIP = 20'((2 ** 20) / TABLE_DEPTH);

	logic [IDX_W-1:0]  idx_q;
	logic [3:0]        step_q;
	logic [IDX_W-1:0]  quo_q;
	logic [30:0]       qd_q;
	logic [KEY_W-1:0]  ekey_q;
	logic [MOVE_W-1:0] emove_q;
	logic [WT_W-1:0]   ewt_q;
	logic [KEY_W-1:0]  pkey_q;
	logic              best_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [WT_W-1:0]   maxw_q;
	logic [SW-1:0]     sum_q;
	logic [MOVE_W-1:0] move_q;
	logic [WT_W-1:0]   w_q;
	logic [MOVE_W-1:0] mv_q;
	logic [RND_W-1:0]  lfsr_q;

	logic [CW-1:0]     cnt_in;
	logic [CW-1:0]     cnt_sat;
	logic [CW-1:0]     mid;
	logic [30:0]       idx_ext;
	logic [29:0]       prod;
	logic [AW-1:0]     addr;
	logic              re;
	logic [EW-1:0]     rdata;
	logic [KEY_W-1:0]  rkey;
	logic [MOVE_W-1:0] rmove;
	logic [WT_W-1:0]   rwt;
	logic [WT_W-1:0]   nmax;
	logic [SW-1:0]     nsum;
	logic [RND_W-1:0]  lfsr_nx;
	logic [SW-1:0]     rem;
	logic              rem_done;

	// Count saturation, midpoint and the reciprocal product for the load address.
	always_comb begin
		cnt_in  = CW'(entry_count);
		cnt_sat = (cnt_in > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_in;
		mid     = lo_q + ((hi_q - lo_q) >> 1);
		idx_ext = 31'(idx_q);
		prod    = 30'(idx_q) * 30'(RECIP);
	end

	// Table port address selection.
	always_comb begin
		if (cmd.mem_wr) begin
			addr = idx_ext[AW-1:0];
		end else if (cmd.srch_rd) begin
			addr = mid[AW-1:0];
		end else begin
			addr = lo_q[AW-1:0];
		end
		re = cmd.srch_rd | cmd.scan_rd;
	end

	stwp_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.mem_wr),
		.re   (re),
		.addr (addr),
		.wdata({ekey_q, emove_q, ewt_q}),
		.rdata(rdata)
	);

	// Per-entry scan arithmetic.
	always_comb begin
		rkey    = rdata[EW-1 -: KEY_W];
		rmove   = rdata[WT_W +: MOVE_W];
		rwt     = rdata[WT_W-1:0];
		nmax    = (rwt > maxw_q) ? rwt : maxw_q;
		nsum    = sum_q + SW'(rwt);
		lfsr_nx = (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : '0);
	end

	stwp_rem #(
		.SW(SW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.rem_start),
		.dividend(lfsr_nx),
		.divisor (nsum),
		.rem     (rem),
		.done    (rem_done)
	);

	// Generator state, reloaded when the seed is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= RND_W'(1);
		end else if (seed_wr) begin
			lfsr_q <= seed;
		end else if (cmd.rem_start) begin
			lfsr_q <= lfsr_nx;
		end
	end

	// Transaction fields and search and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			idx_q   <= entry_index;
			step_q  <= '0;
			ekey_q  <= entry_key;
			emove_q <= entry_move;
			ewt_q   <= entry_weight;
			pkey_q  <= probe_key;
			best_q  <= pick_max;
			cnt_q   <= cnt_sat;
			lo_q    <= '0;
			hi_q    <= cnt_sat - CW'(1);
			maxw_q  <= '0;
			sum_q   <= '0;
			move_q  <= '0;
		end
		// Index modulo the table depth: reciprocal quotient estimate, product,
		// subtraction, then one correction since the estimate may be one low.
		if (cmd.red_step) begin
			step_q <= step_q + 4'd1;
			case (step_q)
				4'd0: quo_q <= prod[29:20];
				4'd1: qd_q <= 31'(quo_q) * DEPTH_W;
				4'd2: idx_q <= IDX_W'(idx_ext - qd_q);
				4'd3: begin
					if (idx_ext >= DEPTH_W) begin
						idx_q <= IDX_W'(idx_ext - DEPTH_W);
					end
				end
				default: ;
			endcase
		end
		if (cmd.srch_upd) begin
			if (pkey_q <= rkey) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + CW'(1);
			end
		end
		if (cmd.scan_upd) begin
			maxw_q <= nmax;
			sum_q  <= nsum;
			w_q    <= rwt;
			mv_q   <= rmove;
			if (best_q && rwt == nmax) begin
				move_q <= rmove;
			end
		end
		if (cmd.pick_upd && rem < SW'(w_q)) begin
			move_q <= mv_q;
		end
		if (cmd.pos_inc) begin
			lo_q <= lo_q + CW'(1);
		end
	end

	// Status back to the controller.
	always_comb begin
		stat.red_last   = (step_q == 4'd3);
		stat.cnt_zero   = (cnt_q == '0);
		stat.lo_lt_hi   = (lo_q < hi_q);
		stat.pos_lt_cnt = (lo_q < cnt_q);
		stat.key_eq     = (rkey == pkey_q);
		stat.need_rem   = !best_q && (nsum != '0);
		stat.rem_done   = rem_done;
	end

	assign chosen_move = move_q;

endmodule

[rtl/stwp_ctrl.sv]
module stwp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 kind,
	input  stwp_pkg::stwp_stat_t stat,
	output stwp_pkg::stwp_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);

	import stwp_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RED  = 4'd1;
	localparam logic [3:0] ST_WR   = 4'd2;
	localparam logic [3:0] ST_SRCH = 4'd3;
	localparam logic [3:0] ST_SCMP = 4'd4;
	localparam logic [3:0] ST_SCAN = 4'd5;
	localparam logic [3:0] ST_SCHK = 4'd6;
	localparam logic [3:0] ST_DIV  = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;

	// Next state and datapath commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nx  = kind ? ST_SRCH : ST_RED;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (stat.red_last) begin
					state_nx = ST_WR;
				end
			end
			ST_WR: begin
				cmd.mem_wr = 1'b1;
				state_nx   = ST_IDLE;
			end
			ST_SRCH: begin
				if (stat.cnt_zero) begin
					state_nx = ST_DONE;
				end else if (stat.lo_lt_hi) begin
					cmd.srch_rd = 1'b1;
					state_nx    = ST_SCMP;
				end else begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCMP: begin
				cmd.srch_upd = 1'b1;
				state_nx     = ST_SRCH;
			end
			ST_SCAN: begin
				if (stat.pos_lt_cnt) begin
					cmd.scan_rd = 1'b1;
					state_nx    = ST_SCHK;
				end else begin
					state_nx = ST_DONE;
				end
			end
			ST_SCHK: begin
				if (!stat.key_eq) begin
					state_nx = ST_DONE;
				end else begin
					cmd.scan_upd = 1'b1;
					if (stat.need_rem) begin
						cmd.rem_start = 1'b1;
						state_nx      = ST_DIV;
					end else begin
						cmd.pos_inc = 1'b1;
						state_nx    = ST_SCAN;
					end
				end
			end
			ST_DIV: begin
				if (stat.rem_done) begin
					cmd.pick_upd = 1'b1;
					cmd.pos_inc  = 1'b1;
					state_nx     = ST_SCAN;
				end
			end
			ST_DONE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

[rtl/sorted_table_weighted_pick.sv]
// Sorted key table with a weighted pick. A transaction is taken when start
// is high and busy is low; busy stays high until the transaction is finished,
// and a probe's chosen_move is shown for exactly one cycle with done high.
// The receiver cannot stall, so done must be sampled on that cycle. A load
// reduces the index modulo the table depth, then writes the table. A probe
// runs a binary search, one table read per step through the single registered
// table port, then scans each matching entry; in random mode an entry with a
// nonzero running sum also waits for a bit-serial remainder unit. The read
// that ends the run of equal keys closes the scan, and a final state shows
// the result.
module sorted_table_weighted_pick #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [stwp_pkg::IDX_W-1:0]    entry_index,
	input  logic [stwp_pkg::KEY_W-1:0]    entry_key,
	input  logic [stwp_pkg::MOVE_W-1:0]   entry_move,
	input  logic [stwp_pkg::WT_W-1:0]     entry_weight,
	input  logic [stwp_pkg::KEY_W-1:0]    probe_key,
	input  logic                          pick_max,
	output logic                          done,
	output logic [stwp_pkg::MOVE_W-1:0]   chosen_move
);

	import stwp_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [RND_W-1:0] seed_q;
	logic             wr_en;
	logic             seed_wr;
	logic             reg_sel;
	stwp_cmd_t        cmd;
	stwp_stat_t       stat;

	// Register write decode.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign seed_wr = wr_en && (reg_sel == REG_SEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seed_q  <= RND_W'(1);
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				REG_SEED:  seed_q  <= pwdata;
				default:   ;
			endcase
		end
	end

	// Register read mux.
	always_comb begin
		unique case (reg_sel)
			REG_COUNT: prdata = 32'(count_q);
			REG_SEED:  prdata = seed_q;
			default:   prdata = '0;
		endcase
	end

	stwp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.kind  (kind),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	stwp_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.entry_count (count_q),
		.seed_wr     (seed_wr),
		.seed        (pwdata),
		.entry_index (entry_index),
		.entry_key   (entry_key),
		.entry_move  (entry_move),
		.entry_weight(entry_weight),
		.probe_key   (probe_key),
		.pick_max    (pick_max),
		.chosen_move (chosen_move)
	);

endmodule
